@@ hw/rtl/tsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, constants and helpers of the tcp syn port counter.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // counter store geometry (port index is the destination port modulo the depth)
  localparam int unsigned PORT_COUNT = 65536;
  localparam int unsigned PORT_BITS  = $clog2(PORT_COUNT);
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned ENTRY_BITS = 2 * COUNT_BITS;

  // widths of the word fields
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CNT_W   = 32;

  // output queue
  localparam int unsigned OUT_DEPTH    = 4;
  localparam int unsigned OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  // frame parsing constants
  localparam logic [15:0] MIN_FRAME    = 16'd54;
  localparam logic [6:0]  POS_MAX      = 7'd127;
  localparam logic [7:0]  ETH_VLAN_HI  = 8'h81;
  localparam logic [7:0]  ETH_IPV4_HI  = 8'h08;
  localparam logic [7:0]  FRAG_HI_MASK = 8'h1f;
  localparam logic [3:0]  IP_VERSION4  = 4'd4;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [1:0]  MAX_TAGS     = 2'd2;

  // word kinds
  localparam logic MODE_FRAME    = 1'b0;
  localparam logic MODE_QUERY    = 1'b1;
  localparam logic KIND_VERDICT  = 1'b0;
  localparam logic KIND_READOUT  = 1'b1;

  localparam int unsigned NUM_PREFIX = 7;
  localparam logic [31:0] PREFIX_MASK [NUM_PREFIX] = '{
    32'hFFFFE000, 32'hFFFFF000, 32'hFFFFF000, 32'hFFFFF000,
    32'hFFFFE000, 32'hFFFFE000, 32'hFFFFC000
  };
  localparam logic [31:0] PREFIX_VALUE [NUM_PREFIX] = '{
    32'hCA264000, 32'hD22D4000, 32'hD22D7000, 32'hD3569000,
    32'hDEC34000, 32'h72D6A000, 32'h72D6C000
  };

  typedef struct packed {
    logic              counted;
    logic              outbound;
    logic [PORT_W-1:0] port;
  } verdict_t;

  typedef struct packed {
    logic              kind;
    logic              counted;
    logic              outbound;
    logic [PORT_W-1:0] port;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic              counted;
    logic              outbound;
    logic [PORT_W-1:0] port;
    logic [CNT_W-1:0]  in_cnt;
    logic [CNT_W-1:0]  out_cnt;
  } res_t;

  typedef struct packed {
    logic                    busy;
    logic [OUT_CNT_BITS-1:0] inflight;
  } store_status_t;

  function automatic logic addr_is_local(input logic [31:0] addr);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_PREFIX; i++) begin
      if ((addr & PREFIX_MASK[i]) == PREFIX_VALUE[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

@@ hw/rtl/tcp_syn_port_counter.sv @@
`timescale 1ns / 1ps
// path: a final byte or a query is registered in the store, then its word is pushed into the output queue
// throughput: one byte or query per cycle while in_ready_o is high, set by one memory port
//   doing a read and a write each cycle with forwarding of the last write
// reset: after rst_ni the counter memory is cleared one entry a cycle, all 65536 entries,
//   with in_ready_o low until the pass is done
// ----------------------------------------------------------------------------
// tcp_syn_port_counter
// Counts inbound and outbound tcp syn frames per destination port.
// ----------------------------------------------------------------------------
module tcp_syn_port_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  input  logic [tsc_pkg::LEN_W-1:0]  frame_length_i,
  input  logic [tsc_pkg::PORT_W-1:0] query_port_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic                      counted_o,
  output logic                      outbound_o,
  output logic [tsc_pkg::PORT_W-1:0] dest_port_o,
  output logic [tsc_pkg::CNT_W-1:0]  in_count_o,
  output logic [tsc_pkg::CNT_W-1:0]  out_count_o
);
  import tsc_pkg::*;

  logic                    in_fire;
  logic                    byte_vld;
  verdict_t                verdict;
  logic                    req_vld;
  req_t                    req;
  logic                    res_vld;
  res_t                    res;
  store_status_t           status;
  logic [OUT_CNT_BITS-1:0] fifo_cnt;
  res_t                    head;

  // leave room in the queue for everything already in the store pipeline
  assign in_ready_o = !status.busy &&
                      ((fifo_cnt + status.inflight) < OUT_CNT_BITS'(OUT_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;
  assign byte_vld   = in_fire && (mode_i == MODE_FRAME);
  assign req_vld    = in_fire && ((mode_i == MODE_QUERY) || last_byte_i);

  always_comb begin
    if (mode_i == MODE_QUERY) begin
      req.kind     = KIND_READOUT;
      req.counted  = 1'b0;
      req.outbound = 1'b0;
      req.port     = query_port_i;
    end else begin
      req.kind     = KIND_VERDICT;
      req.counted  = verdict.counted;
      req.outbound = verdict.outbound;
      req.port     = verdict.port;
    end
  end

  tsc_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_vld_i     (byte_vld),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .frame_length_i (frame_length_i),
    .verdict_o      (verdict)
  );

  tsc_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_vld_i (req_vld),
    .req_i     (req),
    .res_vld_o (res_vld),
    .res_o     (res),
    .status_o  (status)
  );

  tsc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_vld),
    .wdata_i     (res),
    .pop_i       (out_ready_i),
    .not_empty_o (out_valid_o),
    .rdata_o     (head),
    .count_o     (fifo_cnt)
  );

  assign result_kind_o = head.kind;
  assign counted_o     = head.counted;
  assign outbound_o    = head.outbound;
  assign dest_port_o   = head.port;
  assign in_count_o    = head.in_cnt;
  assign out_count_o   = head.out_cnt;

endmodule

@@ hw/rtl/tsc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_parser
// Byte-wise header parser; gives the frame verdict with the final byte.
// ----------------------------------------------------------------------------
module tsc_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_vld_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,
  input  logic [tsc_pkg::LEN_W-1:0] frame_length_i,
  output tsc_pkg::verdict_t        verdict_o
);
  import tsc_pkg::*;

  logic [6:0]  pos_q, pos_d;
  logic [1:0]  vlan_q, vlan_d;
  logic        ipv4_q, ipv4_d;
  logic [3:0]  hw_q, hw_d;
  logic        ok_q, ok_d;
  logic [15:0] tot_q, tot_d;
  logic [31:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic        syn_q, syn_d;
  logic [7:0]  type_q, type_d;

  logic [6:0]  base;
  logic [6:0]  hdr_start;
  logic [6:0]  ofs;
  logic [3:0]  hw_eff;
  logic [6:0]  tcp_ofs;
  logic [7:0]  s_n;
  logic [7:0]  t13;
  logic [7:0]  need;
  logic [15:0] room;

  always_comb begin
    pos_d  = pos_q;
    vlan_d = vlan_q;
    ipv4_d = ipv4_q;
    hw_d   = hw_q;
    ok_d   = ok_q;
    tot_d  = tot_q;
    src_d  = src_q;
    dst_d  = dst_q;
    syn_d  = syn_q;
    type_d = type_q;

    base      = 7'd12 + {3'b000, vlan_q, 2'b00};
    hdr_start = base + 7'd2;
    ofs       = pos_q - hdr_start;
    hw_eff    = (ofs == 7'd0) ? data_byte_i[3:0] : hw_q;
    tcp_ofs   = {1'b0, hw_eff, 2'b00};

    if (ok_q) begin
      if (!ipv4_q) begin
        // ethertype, possibly behind up to two vlan tags
        if (pos_q == base) begin
          type_d = data_byte_i;
        end else if (pos_q == base + 7'd1) begin
          if (vlan_q < MAX_TAGS && type_q == ETH_VLAN_HI && data_byte_i == 8'd0) begin
            vlan_d = vlan_q + 2'd1;
          end else if (type_q == ETH_IPV4_HI && data_byte_i == 8'd0) begin
            ipv4_d = 1'b1;
          end else begin
            ok_d = 1'b0;
          end
        end
      end else if (pos_q >= hdr_start) begin
        if (ofs == 7'd0) begin
          if (data_byte_i[7:4] != IP_VERSION4) ok_d = 1'b0;
          hw_d = data_byte_i[3:0];
        end
        if (ofs == 7'd2) tot_d[15:8] = data_byte_i;
        if (ofs == 7'd3) tot_d[7:0] = data_byte_i;
        if (ofs == 7'd6 && (data_byte_i & FRAG_HI_MASK) != 8'd0) ok_d = 1'b0;
        if (ofs == 7'd7 && data_byte_i != 8'd0) ok_d = 1'b0;
        if (ofs == 7'd9 && data_byte_i != PROTO_TCP) ok_d = 1'b0;
        if (ofs >= 7'd12 && ofs <= 7'd15) src_d = {src_q[23:0], data_byte_i};
        if (ofs == tcp_ofs + 7'd2) dst_d[15:8] = data_byte_i;
        if (ofs == tcp_ofs + 7'd3) dst_d[7:0] = data_byte_i;
        if (ofs == tcp_ofs + 7'd13) syn_d = data_byte_i[1] & ~data_byte_i[4];
      end
    end

    if (pos_q != POS_MAX) pos_d = pos_q + 7'd1;
  end

  // verdict from the state as it stands after this byte
  always_comb begin
    s_n  = 8'd14 + {4'b0000, vlan_d, 2'b00};
    t13  = {2'b00, hw_d, 2'b00} + 8'd13;
    need = s_n + ((t13 > 8'd15) ? t13 : 8'd15) + 8'd1;
    room = frame_length_i - {8'h00, s_n};
    verdict_o.counted = (frame_length_i >= MIN_FRAME) && ipv4_d && ok_d && syn_d &&
                        ({1'b0, pos_d} >= need) && (tot_d <= room);
    verdict_o.outbound = addr_is_local(src_d);
    verdict_o.port     = dst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      vlan_q <= '0;
      ipv4_q <= 1'b0;
      hw_q   <= '0;
      ok_q   <= 1'b1;
      tot_q  <= '0;
      src_q  <= '0;
      dst_q  <= '0;
      syn_q  <= 1'b0;
      type_q <= '0;
    end else if (byte_vld_i) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        vlan_q <= '0;
        ipv4_q <= 1'b0;
        hw_q   <= '0;
        ok_q   <= 1'b1;
        tot_q  <= '0;
        src_q  <= '0;
        dst_q  <= '0;
        syn_q  <= 1'b0;
        type_q <= '0;
      end else begin
        pos_q  <= pos_d;
        vlan_q <= vlan_d;
        ipv4_q <= ipv4_d;
        hw_q   <= hw_d;
        ok_q   <= ok_d;
        tot_q  <= tot_d;
        src_q  <= src_d;
        dst_q  <= dst_d;
        syn_q  <= syn_d;
        type_q <= type_d;
      end
    end
  end

endmodule

@@ hw/rtl/tsc_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_store
// Per-port counter memory with read-modify-write, forwarding and clear pass.
// ----------------------------------------------------------------------------
module tsc_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_vld_i,
  input  tsc_pkg::req_t          req_i,
  output logic                   res_vld_o,
  output tsc_pkg::res_t          res_o,
  output tsc_pkg::store_status_t status_o
);
  import tsc_pkg::*;

  logic [ENTRY_BITS-1:0] mem [PORT_COUNT];

  logic [PORT_BITS:0]    clr_cnt_q;
  logic                  clearing;
  logic                  req_vld_q;
  req_t                  req_q;
  logic [ENTRY_BITS-1:0] rdata_q;

  logic                  fwd_vld_q;
  logic [PORT_BITS-1:0]  fwd_idx_q;
  logic [ENTRY_BITS-1:0] fwd_data_q;

  logic [PORT_BITS-1:0]  rd_idx;
  logic [PORT_BITS-1:0]  cur_idx;
  logic [ENTRY_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] cur_in, cur_out, new_in, new_out;
  logic                  wr_en;
  logic [ENTRY_BITS-1:0] wr_data;

  assign clearing = ~clr_cnt_q[PORT_BITS];
  assign rd_idx   = req_i.port[PORT_BITS-1:0];
  assign cur_idx  = req_q.port[PORT_BITS-1:0];

  // the previous write lands on the same edge as this read, so forward it
  assign cur     = (fwd_vld_q && fwd_idx_q == cur_idx) ? fwd_data_q : rdata_q;
  assign cur_in  = cur[COUNT_BITS-1:0];
  assign cur_out = cur[ENTRY_BITS-1:COUNT_BITS];

  always_comb begin
    new_in  = cur_in;
    new_out = cur_out;
    if (req_q.outbound) new_out = cur_out + 1'b1;
    else                new_in  = cur_in + 1'b1;
  end

  assign wr_en   = req_vld_q && (req_q.kind == KIND_VERDICT) && req_q.counted;
  assign wr_data = {new_out, new_in};

  always_comb begin
    res_vld_o = req_vld_q;
    res_o     = '0;
    res_o.kind = req_q.kind;
    if (req_q.kind == KIND_READOUT) begin
      res_o.port    = req_q.port;
      res_o.in_cnt  = CNT_W'(cur_in);
      res_o.out_cnt = CNT_W'(cur_out);
    end else if (req_q.counted) begin
      res_o.counted  = 1'b1;
      res_o.outbound = req_q.outbound;
      res_o.port     = req_q.port;
      res_o.in_cnt   = CNT_W'(new_in);
      res_o.out_cnt  = CNT_W'(new_out);
    end
  end

  assign status_o.busy     = clearing;
  assign status_o.inflight = OUT_CNT_BITS'(req_vld_q);

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem[clr_cnt_q[PORT_BITS-1:0]] <= '0;
    end else if (wr_en) begin
      mem[cur_idx] <= wr_data;
    end
    if (req_vld_i) begin
      rdata_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_i;
    fwd_idx_q  <= cur_idx;
    fwd_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      req_vld_q <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (clearing) clr_cnt_q <= clr_cnt_q + 1'b1;
      req_vld_q <= req_vld_i;
      fwd_vld_q <= wr_en;
    end
  end

endmodule

@@ hw/rtl/tsc_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_out_fifo
// Small result queue that decouples the store pipeline from the output side.
// ----------------------------------------------------------------------------
module tsc_out_fifo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  tsc_pkg::res_t                        wdata_i,
  input  logic                                 pop_i,
  output logic                                 not_empty_o,
  output tsc_pkg::res_t                        rdata_o,
  output logic [tsc_pkg::OUT_CNT_BITS-1:0]     count_o
);
  import tsc_pkg::*;

  res_t                    slot [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_BITS-1:0] cnt_q;
  logic                    do_pop;

  assign not_empty_o = (cnt_q != '0);
  assign rdata_o     = slot[rd_ptr_q];
  assign count_o     = cnt_q;
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) slot[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hw/rtl/tsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_checker
// Port-level checks of the tcp syn port counter, bound to the top level.
// ----------------------------------------------------------------------------
module tsc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      mode_i,
  input logic                      last_byte_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      result_kind_o,
  input logic                      counted_o,
  input logic                      outbound_o,
  input logic [tsc_pkg::PORT_W-1:0] dest_port_o,
  input logic [tsc_pkg::CNT_W-1:0]  in_count_o,
  input logic [tsc_pkg::CNT_W-1:0]  out_count_o
);
  import tsc_pkg::*;

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o) &&
      $stable(counted_o) && $stable(outbound_o) && $stable(dest_port_o) &&
      $stable(in_count_o) && $stable(out_count_o))
    else $error("output word changed while stalled");

  // a final byte or a query always leads to a valid word after the store register and the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == MODE_QUERY || last_byte_i) |-> ##2 out_valid_o)
    else $error("missing result word");

  // an uncounted verdict carries nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_VERDICT && !counted_o |->
      !outbound_o && dest_port_o == '0 && in_count_o == '0 && out_count_o == '0)
    else $error("uncounted verdict with payload");

  // a readout never claims a count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_READOUT |-> !counted_o && !outbound_o)
    else $error("readout with verdict flags");

endmodule

bind tcp_syn_port_counter tsc_checker u_tsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .mode_i        (mode_i),
  .last_byte_i   (last_byte_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .counted_o     (counted_o),
  .outbound_o    (outbound_o),
  .dest_port_o   (dest_port_o),
  .in_count_o    (in_count_o),
  .out_count_o   (out_count_o)
);
